// File: hw/rtl/pft_pkg.sv
`default_nettype none

package pft_pkg;

    // Register indexes of the configuration port
    localparam logic [7:0] CFG_NUM_VERTS = 8'd0;
    localparam logic [7:0] CFG_CLOCKWISE = 8'd1;

    // Face geometry
    localparam int MIN_TRI_CORNERS = 3;  // fewest corners that make a triangle
    localparam int FAN_FIRST       = 2;  // corner index of the first fan "cur"

    // Corner count field of a face command, wide enough for the default 64-corner face buffer
    localparam int CNT_W = 7;

    typedef struct packed {
        logic signed [31:0] corner_index;
        logic               face_end;
        logic               mesh_start;
    } t_in;

    typedef struct packed {
        logic [30:0] tri_first;
        logic [30:0] tri_second;
        logic [30:0] tri_third;
        logic        bad_face;
        logic        face_last;
    } t_out;

    // One finished face handed from the front to the back
    typedef struct packed {
        logic             bad;
        logic             bank;
        logic [CNT_W-1:0] count;
    } t_face_cmd;

    // Back tells the front a buffer bank is free again
    typedef struct packed {
        logic vld;
        logic bank;
    } t_done;

endpackage

`default_nettype wire

// File: hw/rtl/polygon_fan_triangulator_unit.sv
// Triangle-fan triangulator. Polygon corner indices stream in one per transaction;
// face_end marks the last corner of a face and mesh_start opens a new mesh (and
// clears a halt). The front stage takes one corner per cycle while its write buffer
// is free and the queue is not full, range-checks it against the vertex limit and
// writes it into one of two face buffers. At face end a face command goes to a
// two-entry queue; the back stage then reads the buffer and emits count-2
// triangles around corner 0, one per cycle while the output is not stalled, after
// a setup (pop, origin read, second-corner read). A bad face (negative index,
// index >= vertex limit, or more than MAX_FACE_CORNERS corners) yields a single
// result with bad_face=1 and zero indices, after which corners are dropped until
// mesh_start. Faces of one or two corners yield nothing. Because there are two
// buffers, the front stalls on a third face only while the older of the two
// earlier ones is still queued or being emitted. Config writes (index 0: vertex
// limit, 1: clockwise_order) are meant for idle periods.
`default_nettype none

module polygon_fan_triangulator_unit #(
    parameter int MAX_FACE_CORNERS = 64
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    // corner input
    input  wire logic           i_in_valid,
    output logic                o_in_ready,
    input  wire pft_pkg::t_in   i_in,
    // triangle output
    output logic                o_out_valid,
    input  wire logic           i_out_ready,
    output pft_pkg::t_out       o_out,
    // config write
    input  wire logic           i_cfg_valid,
    output logic                o_cfg_ready,
    input  wire logic [7:0]     i_cfg_index,
    input  wire logic [31:0]    i_cfg_data
);
    import pft_pkg::*;

    localparam int AW = $clog2(MAX_FACE_CORNERS);

    // config registers
    logic [30:0] r_num_verts;
    logic        r_clockwise;

    // front -> buffer write
    logic        wr_en;
    logic [AW:0] wr_addr;
    logic [30:0] wr_data;

    // front -> queue -> back
    logic        push;
    logic        pop;
    logic        q_empty;
    logic        q_full;
    t_face_cmd   cmd_in;
    t_face_cmd   cmd_out;
    t_done       done;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_num_verts <= '0;
            r_clockwise <= 1'b1;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_NUM_VERTS: r_num_verts <= i_cfg_data[30:0];
                CFG_CLOCKWISE: r_clockwise <= i_cfg_data[0];
                default:       ;  // unknown index, write dropped
            endcase
        end
    end

    pft_front #(
        .MAX_FACE_CORNERS (MAX_FACE_CORNERS)
    ) u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_in           (i_in),
        .i_num_verts    (r_num_verts),
        .o_wr_en        (wr_en),
        .o_wr_addr      (wr_addr),
        .o_wr_data      (wr_data),
        .o_push         (push),
        .o_cmd          (cmd_in),
        .i_q_full       (q_full),
        .i_done         (done)
    );

    pft_face_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (cmd_in),
        .i_pop   (pop),
        .o_cmd   (cmd_out),
        .o_empty (q_empty),
        .o_full  (q_full)
    );

    pft_back #(
        .MAX_FACE_CORNERS (MAX_FACE_CORNERS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_wr_en     (wr_en),
        .i_wr_addr   (wr_addr),
        .i_wr_data   (wr_data),
        .i_cmd       (cmd_out),
        .i_q_empty   (q_empty),
        .o_pop       (pop),
        .o_done      (done),
        .i_clockwise (r_clockwise),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out       (o_out)
    );

endmodule

`default_nettype wire

// File: hw/rtl/pft_front.sv
`default_nettype none

module pft_front #(
    parameter int MAX_FACE_CORNERS = 64
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_in_valid,
    output logic                                     o_in_ready,
    input  wire pft_pkg::t_in                        i_in,
    input  wire logic [30:0]                         i_num_verts,
    output logic                                     o_wr_en,
    output logic [$clog2(MAX_FACE_CORNERS):0]        o_wr_addr,
    output logic [30:0]                              o_wr_data,
    output logic                                     o_push,
    output pft_pkg::t_face_cmd                       o_cmd,
    input  wire logic                                i_q_full,
    input  wire pft_pkg::t_done                      i_done
);
    import pft_pkg::*;

    localparam int AW = $clog2(MAX_FACE_CORNERS);
    localparam int HW = $clog2(MAX_FACE_CORNERS + 1);

    logic          r_halted;
    logic          r_inv;
    logic [HW-1:0] r_held;
    logic          r_wbank;
    logic [1:0]    r_busy;

    logic          fire;
    logic          halted_eff;
    logic          inv_eff;
    logic [HW-1:0] held_eff;
    logic          bad_corner;
    logic          room;
    logic [HW-1:0] held_n;
    logic          inv_n;

    always_comb begin
        fire       = i_in_valid && o_in_ready;
        halted_eff = r_halted && !i_in.mesh_start;
        inv_eff    = r_inv && !i_in.mesh_start;
        held_eff   = i_in.mesh_start ? '0 : r_held;
        bad_corner = i_in.corner_index[31] || (i_in.corner_index[30:0] >= i_num_verts);
        room       = held_eff < HW'(MAX_FACE_CORNERS);
        held_n     = room ? held_eff + HW'(1) : held_eff;
        inv_n      = inv_eff || bad_corner || !room;
    end

    assign o_in_ready = !r_busy[r_wbank] && !i_q_full;

    assign o_wr_en   = fire && !halted_eff && room;
    assign o_wr_addr = {r_wbank, held_eff[AW-1:0]};
    assign o_wr_data = i_in.corner_index[30:0];

    assign o_push      = fire && !halted_eff && i_in.face_end &&
                         (inv_n || (held_n >= HW'(MIN_TRI_CORNERS)));
    assign o_cmd.bad   = inv_n;
    assign o_cmd.bank  = r_wbank;
    assign o_cmd.count = CNT_W'(held_n);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_halted <= 1'b0;
            r_inv    <= 1'b0;
            r_held   <= '0;
            r_wbank  <= 1'b0;
            r_busy   <= '0;
        end else begin
            if (fire && !halted_eff) begin
                if (i_in.face_end) begin
                    r_held   <= '0;
                    r_inv    <= 1'b0;
                    r_halted <= inv_n;
                end else begin
                    r_held   <= held_n;
                    r_inv    <= inv_n;
                    r_halted <= 1'b0;
                end
            end
            if (i_done.vld) begin
                r_busy[i_done.bank] <= 1'b0;
            end
            if (o_push) begin
                r_busy[r_wbank] <= 1'b1;
                r_wbank         <= !r_wbank;
            end
        end
    end

endmodule

`default_nettype wire

// File: hw/rtl/pft_face_queue.sv
`default_nettype none

module pft_face_queue (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_push,
    input  wire pft_pkg::t_face_cmd i_cmd,
    input  wire logic               i_pop,
    output pft_pkg::t_face_cmd      o_cmd,
    output logic                    o_empty,
    output logic                    o_full
);
    import pft_pkg::*;

    t_face_cmd  r_slot [2];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_cnt;

    assign o_cmd   = r_slot[r_rp];
    assign o_empty = (r_cnt == 2'd0);
    assign o_full  = (r_cnt == 2'd2);

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wp] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= !r_wp;
            end
            if (i_pop) begin
                r_rp <= !r_rp;
            end
            case ({i_push, i_pop})
                2'b10:   r_cnt <= r_cnt + 2'd1;
                2'b01:   r_cnt <= r_cnt - 2'd1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule

`default_nettype wire

// File: hw/rtl/pft_back.sv
`default_nettype none

module pft_back #(
    parameter int MAX_FACE_CORNERS = 64
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_wr_en,
    input  wire logic [$clog2(MAX_FACE_CORNERS):0]   i_wr_addr,
    input  wire logic [30:0]                         i_wr_data,
    input  wire pft_pkg::t_face_cmd                  i_cmd,
    input  wire logic                                i_q_empty,
    output logic                                     o_pop,
    output pft_pkg::t_done                           o_done,
    input  wire logic                                i_clockwise,
    output logic                                     o_out_valid,
    input  wire logic                                i_out_ready,
    output pft_pkg::t_out                            o_out
);
    import pft_pkg::*;

    localparam int AW = $clog2(MAX_FACE_CORNERS);
    localparam int HW = $clog2(MAX_FACE_CORNERS + 1);

    typedef enum logic [2:0] {
        B_IDLE,
        B_ORG,
        B_PRV,
        B_TRI,
        B_BAD
    } t_state;

    // two face buffers, bank bit on top of the address
    logic [30:0] r_mem [2 ** (AW + 1)];
    logic [30:0] r_rdata;
    logic [AW:0] rd_addr;

    t_state        r_state, n_state;
    logic          r_bank, n_bank;
    logic [HW-1:0] r_cnt, n_cnt;
    logic [HW-1:0] r_idx, n_idx;
    logic [30:0]   r_origin, n_origin;
    logic [30:0]   r_prev, n_prev;
    logic          r_out_vld, n_out_vld;
    t_out          r_out, n_out;

    logic          slot_free;
    logic [HW-1:0] idx_inc;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rdata <= r_mem[rd_addr];
    end

    always_comb begin
        n_state   = r_state;
        n_bank    = r_bank;
        n_cnt     = r_cnt;
        n_idx     = r_idx;
        n_origin  = r_origin;
        n_prev    = r_prev;
        n_out_vld = r_out_vld && !i_out_ready;
        n_out     = r_out;
        o_pop     = 1'b0;
        o_done    = '0;
        slot_free = !r_out_vld || i_out_ready;
        idx_inc   = r_idx + HW'(1);
        rd_addr   = {r_bank, r_idx[AW-1:0]};
        unique case (r_state)
            B_IDLE: begin
                if (!i_q_empty) begin
                    o_pop   = 1'b1;
                    n_bank  = i_cmd.bank;
                    n_cnt   = HW'(i_cmd.count);
                    rd_addr = {i_cmd.bank, {AW{1'b0}}};
                    n_state = i_cmd.bad ? B_BAD : B_ORG;
                end
            end
            B_ORG: begin
                n_origin = r_rdata;
                rd_addr  = {r_bank, AW'(1)};
                n_state  = B_PRV;
            end
            B_PRV: begin
                n_prev  = r_rdata;
                rd_addr = {r_bank, AW'(FAN_FIRST)};
                n_idx   = HW'(FAN_FIRST);
                n_state = B_TRI;
            end
            B_TRI: begin
                if (slot_free) begin
                    n_out_vld        = 1'b1;
                    n_out.tri_first  = r_origin;
                    n_out.tri_second = i_clockwise ? r_prev : r_rdata;
                    n_out.tri_third  = i_clockwise ? r_rdata : r_prev;
                    n_out.bad_face   = 1'b0;
                    n_out.face_last  = (idx_inc == r_cnt);
                    n_prev           = r_rdata;
                    if (idx_inc == r_cnt) begin
                        o_done.vld  = 1'b1;
                        o_done.bank = r_bank;
                        n_state     = B_IDLE;
                    end else begin
                        n_idx   = idx_inc;
                        rd_addr = {r_bank, idx_inc[AW-1:0]};
                    end
                end
            end
            B_BAD: begin
                if (slot_free) begin
                    n_out_vld       = 1'b1;
                    n_out           = '0;
                    n_out.bad_face  = 1'b1;
                    n_out.face_last = 1'b1;
                    o_done.vld      = 1'b1;
                    o_done.bank     = r_bank;
                    n_state         = B_IDLE;
                end
            end
            default: n_state = B_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= B_IDLE;
            r_out_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_out_vld <= n_out_vld;
        end
        r_bank   <= n_bank;
        r_cnt    <= n_cnt;
        r_idx    <= n_idx;
        r_origin <= n_origin;
        r_prev   <= n_prev;
        r_out    <= n_out;
    end

    assign o_out_valid = r_out_vld;
    assign o_out       = r_out;

endmodule

`default_nettype wire

// File: hw/rtl/pft_checker.sv
`default_nettype none

module pft_checker (
    input wire logic          i_clk,
    input wire logic          i_rst_n,
    input wire logic          o_out_valid,
    input wire logic          i_out_ready,
    input wire pft_pkg::t_out o_out
);

    // stalled result stays offered
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid)
        else $error("result dropped while stalled");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> $stable(o_out))
        else $error("result changed while stalled");

    // a bad-face result carries no triangle and closes the face
    a_bad_shape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out.bad_face |->
            o_out.face_last && (o_out.tri_first == 31'd0) &&
            (o_out.tri_second == 31'd0) && (o_out.tri_third == 31'd0))
        else $error("bad-face result malformed");

    // nothing comes out right after reset
    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

endmodule

bind polygon_fan_triangulator_unit pft_checker u_pft_checker (.*);

`default_nettype wire
